@@ rtl/core/audio_iir_filter_assert.svh @@
// Assertion macros used by the audio IIR filter top level.
`ifndef AUDIO_IIR_FILTER_ASSERT_SVH
`define AUDIO_IIR_FILTER_ASSERT_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define AIF_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("audio_iir_filter: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define AIF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("audio_iir_filter: next-cycle check failed");

`endif

@@ rtl/core/aif_pkg.sv @@
// Package with the types, constants and register map of the audio IIR filter.
`timescale 1ns / 1ps
`default_nettype none

package aif_pkg;

    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_BITS      = 32;
    localparam int COEF_FRAC_BITS = 30;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    // Five products, two of them negated, plus the rounding half.
    localparam int ACC_BITS       = PROD_BITS + 4;

    localparam int APB_DATA_BITS  = 32;
    localparam int REG_IDX_BITS   = 3;
    localparam int APB_ADDR_BITS  = REG_IDX_BITS + 2;
    localparam int MODE_BITS      = 2;

    typedef logic signed [SAMPLE_BITS-1:0] aif_sample_t;
    typedef logic signed [COEF_BITS-1:0]   aif_coef_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_BYPASS = 2'd0,
        MODE_FIRST  = 2'd1,
        MODE_BIQUAD = 2'd2
    } aif_mode_t;

    localparam logic [REG_IDX_BITS-1:0] REG_FILTER_MODE    = 3'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_FIRST_GAIN     = 3'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_FIRST_FEEDBACK = 3'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_B0        = 3'd3;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_B1        = 3'd4;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_B2        = 3'd5;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_A1        = 3'd6;
    localparam logic [REG_IDX_BITS-1:0] REG_COEF_A2        = 3'd7;

    // Unity gain in Q2.30.
    localparam aif_coef_t COEF_UNITY = aif_coef_t'(1) <<< COEF_FRAC_BITS;

    typedef struct packed {
        logic [MODE_BITS-1:0] filter_mode;
        aif_coef_t            first_gain;
        aif_coef_t            first_feedback;
        aif_coef_t            coef_b0;
        aif_coef_t            coef_b1;
        aif_coef_t            coef_b2;
        aif_coef_t            coef_a1;
        aif_coef_t            coef_a2;
    } aif_cfg_t;

    typedef struct packed {
        aif_sample_t x1;
        aif_sample_t x2;
        aif_sample_t y1;
        aif_sample_t y2;
    } aif_hist_t;

endpackage

`default_nettype wire

@@ rtl/core/aif_cfg_regs.sv @@
// APB register file holding the filter mode and the Q2.30 coefficients.
`timescale 1ns / 1ps
`default_nettype none

module aif_cfg_regs (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [aif_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [aif_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [aif_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                   pready,
    output aif_pkg::aif_cfg_t                      cfg
);
    import aif_pkg::*;

    aif_cfg_t                cfg_reg;
    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    wr_en;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_BITS-1:2];
    assign wr_en   = psel && penable && pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.filter_mode    <= MODE_BYPASS;
            cfg_reg.first_gain     <= COEF_UNITY;
            cfg_reg.first_feedback <= '0;
            cfg_reg.coef_b0        <= COEF_UNITY;
            cfg_reg.coef_b1        <= '0;
            cfg_reg.coef_b2        <= '0;
            cfg_reg.coef_a1        <= '0;
            cfg_reg.coef_a2        <= '0;
        end
        else if (wr_en)
        begin
            unique case (reg_idx)
                REG_FILTER_MODE:    cfg_reg.filter_mode    <= pwdata[MODE_BITS-1:0];
                REG_FIRST_GAIN:     cfg_reg.first_gain     <= pwdata;
                REG_FIRST_FEEDBACK: cfg_reg.first_feedback <= pwdata;
                REG_COEF_B0:        cfg_reg.coef_b0        <= pwdata;
                REG_COEF_B1:        cfg_reg.coef_b1        <= pwdata;
                REG_COEF_B2:        cfg_reg.coef_b2        <= pwdata;
                REG_COEF_A1:        cfg_reg.coef_a1        <= pwdata;
                REG_COEF_A2:        cfg_reg.coef_a2        <= pwdata;
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_FILTER_MODE:    prdata = {{(APB_DATA_BITS-MODE_BITS){1'b0}},
                                          cfg_reg.filter_mode};
            REG_FIRST_GAIN:     prdata = cfg_reg.first_gain;
            REG_FIRST_FEEDBACK: prdata = cfg_reg.first_feedback;
            REG_COEF_B0:        prdata = cfg_reg.coef_b0;
            REG_COEF_B1:        prdata = cfg_reg.coef_b1;
            REG_COEF_B2:        prdata = cfg_reg.coef_b2;
            REG_COEF_A1:        prdata = cfg_reg.coef_a1;
            REG_COEF_A2:        prdata = cfg_reg.coef_a2;
            default:            prdata = '0;
        endcase
    end

endmodule

`default_nettype wire

@@ rtl/core/aif_iir_core.sv @@
// Single-pass filter arithmetic: five products, exact sum, rounding and saturation.
`timescale 1ns / 1ps
`default_nettype none

module aif_iir_core (
    input  aif_pkg::aif_cfg_t    cfg,
    input  aif_pkg::aif_sample_t x,
    input  aif_pkg::aif_hist_t   hist,
    output aif_pkg::aif_sample_t y,
    output logic                 clip
);
    import aif_pkg::*;

    localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
        {{(ACC_BITS-COEF_FRAC_BITS){1'b0}}, 1'b1, {(COEF_FRAC_BITS-1){1'b0}}};

    aif_coef_t                   c0, c1, c2, c3, c4;
    logic                        bypass;
    logic                        neg_fb;
    logic signed [PROD_BITS-1:0] prod0, prod1, prod2, prod3, prod4;
    logic signed [ACC_BITS-1:0]  term3, term4;
    logic signed [ACC_BITS-1:0]  acc;
    logic signed [ACC_BITS-1:0]  shifted;
    logic [ACC_BITS-SAMPLE_BITS:0] top_bits;
    logic                        fits;

    // First order shares the multipliers on x and y1 with the biquad.
    always_comb
    begin
        c0     = '0;
        c1     = '0;
        c2     = '0;
        c3     = '0;
        c4     = '0;
        neg_fb = 1'b0;
        bypass = 1'b0;
        unique case (cfg.filter_mode)
            MODE_FIRST:
            begin
                c0 = cfg.first_gain;
                c3 = cfg.first_feedback;
            end
            MODE_BIQUAD:
            begin
                c0     = cfg.coef_b0;
                c1     = cfg.coef_b1;
                c2     = cfg.coef_b2;
                c3     = cfg.coef_a1;
                c4     = cfg.coef_a2;
                neg_fb = 1'b1;
            end
            default: bypass = 1'b1;
        endcase
    end

    assign prod0 = c0 * x;
    assign prod1 = c1 * hist.x1;
    assign prod2 = c2 * hist.x2;
    assign prod3 = c3 * hist.y1;
    assign prod4 = c4 * hist.y2;

    assign term3 = neg_fb ? -ACC_BITS'(prod3) : ACC_BITS'(prod3);
    assign term4 = neg_fb ? -ACC_BITS'(prod4) : ACC_BITS'(prod4);

    assign acc = ACC_BITS'(prod0) + ACC_BITS'(prod1) + ACC_BITS'(prod2)
               + term3 + term4 + ROUND_HALF;

    // Arithmetic shift floors, so adding one half first gives round half up.
    assign shifted  = acc >>> COEF_FRAC_BITS;
    assign top_bits = shifted[ACC_BITS-1:SAMPLE_BITS-1];
    assign fits     = (&top_bits) || !(|top_bits);

    always_comb
    begin
        if (bypass)
        begin
            y    = x;
            clip = 1'b0;
        end
        else if (fits)
        begin
            y    = shifted[SAMPLE_BITS-1:0];
            clip = 1'b0;
        end
        else
        begin
            y    = {shifted[ACC_BITS-1], {(SAMPLE_BITS-1){~shifted[ACC_BITS-1]}}};
            clip = 1'b1;
        end
    end

endmodule

`default_nettype wire

@@ rtl/core/audio_iir_filter.sv @@
// Top level of the audio IIR filter: input register, filter pass, result register.
`timescale 1ns / 1ps
`default_nettype none

// The filter takes one signed 24-bit sample per transfer and returns one
// filtered, saturated sample with a clip flag, in bypass, first-order or
// direct form I biquad mode as set through the APB registers. It accepts a
// sample in every cycle while the result side does not stall; a result passes
// through the input register and then the result register. The rate of
// one sample per cycle is set by the feedback loop from the output history
// through the five Q2.30 multipliers, the adder tree and the saturation into
// the next sample's history. Stalling the result side holds the input register
// and then stalls the input side. Coefficients should only be written while no
// sample is in flight. Reset clears the filter history to zero.
module audio_iir_filter (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [aif_pkg::APB_ADDR_BITS-1:0] paddr,
    input  wire logic [aif_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic      [aif_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                                   pready,
    input  wire logic                              sample_valid,
    output logic                                   sample_stall,
    input  wire logic [aif_pkg::SAMPLE_BITS-1:0]   sample_in,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output logic      [aif_pkg::SAMPLE_BITS-1:0]   sample_out,
    output logic                                   clipped
);
    import aif_pkg::*;

    `include "audio_iir_filter_assert.svh"

    aif_cfg_t    cfg;
    aif_sample_t x_reg;
    logic        x_valid_reg;
    aif_hist_t   hist_reg;
    aif_hist_t   hist_next;
    aif_sample_t y_next;
    logic        clip_next;
    aif_sample_t sample_out_reg;
    logic        clipped_reg;
    logic        result_valid_reg;
    logic        in_xfer;
    logic        advance;

    aif_cfg_regs u_cfg_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    aif_iir_core u_iir_core (
        .cfg  (cfg),
        .x    (x_reg),
        .hist (hist_reg),
        .y    (y_next),
        .clip (clip_next)
    );

    // The sample in the input register moves on when the result register is
    // empty or its result is being transferred out in this cycle.
    assign advance      = x_valid_reg && (!result_valid_reg || !result_stall);
    assign sample_stall = x_valid_reg && !advance;
    assign in_xfer      = sample_valid && !sample_stall;

    assign hist_next.x1 = x_reg;
    assign hist_next.x2 = hist_reg.x1;
    assign hist_next.y1 = y_next;
    assign hist_next.y2 = hist_reg.y1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_valid_reg      <= 1'b0;
            result_valid_reg <= 1'b0;
            hist_reg         <= '0;
        end
        else
        begin
            if (in_xfer)
                x_valid_reg <= 1'b1;
            else if (advance)
                x_valid_reg <= 1'b0;

            if (advance)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;

            if (advance)
                hist_reg <= hist_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
            x_reg <= sample_in;
        if (advance)
        begin
            sample_out_reg <= y_next;
            clipped_reg    <= clip_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign sample_out   = sample_out_reg;
    assign clipped      = clipped_reg;

    `AIF_ASSERT_NEXT(a_input_hist_shift, advance,
        (hist_reg.x1 == $past(x_reg)) && (hist_reg.x2 == $past(hist_reg.x1)))
    `AIF_ASSERT_NEXT(a_result_matches_feedback, advance,
        result_valid && (sample_out == hist_reg.y1) && (hist_reg.y2 == $past(hist_reg.y1)))
    `AIF_ASSERT_NEXT(a_bypass_passes_sample,
        advance && (cfg.filter_mode != MODE_FIRST) && (cfg.filter_mode != MODE_BIQUAD),
        !clipped && (sample_out == $past(x_reg)))
    `AIF_ASSERT_NOW(a_clip_at_rail, result_valid && clipped,
        (sample_out == {1'b0, {(SAMPLE_BITS-1){1'b1}}})
        || (sample_out == {1'b1, {(SAMPLE_BITS-1){1'b0}}}))

endmodule

`default_nettype wire
